### hw/rtl/vsst_pkg.sv
// ============================================================================
// vsst_pkg
// Shared constants, register indexes and stage structs of the variable
// stiffness spring torque block.
// ============================================================================
package vsst_pkg;

    // Widths of the fixed-point ports and registers.
    localparam int ANGLE_W  = 16;
    localparam int LEN_W    = 16;
    localparam int KS_W     = 31;
    localparam int DLIM_W   = 13;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;

    // Pipeline depths.
    localparam int TRIG_STEPS = 16;
    localparam int DIV_STAGES = 64;
    localparam int SCL_DELAY  = 6;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [31:0] CORDIC_K    = 32'sd652032874;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRING_GAIN      = 2'd0,
        REG_LEVER_LENGTH     = 2'd1,
        REG_PULLEY_RADIUS    = 2'd2,
        REG_DEFLECTION_LIMIT = 2'd3
    } cfg_index_t;

    // Travels beside the trig pipeline.
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        cinf;
        logic        perr;
        logic        flip;
    } cordic_side_t;

    // Travels beside the divider.
    typedef struct packed {
        logic [30:0] smag;
        logic [30:0] cmag;
        logic        tneg;
        logic        sneg;
        logic        perr;
        logic        cinf;
    } div_side_t;

    // Travels beside the output multipliers.
    typedef struct packed {
        logic [63:0] c;
        logic        cinf;
        logic        tneg;
        logic        sneg;
        logic        perr;
    } scl_side_t;

endpackage

### hw/rtl/vsst_cordic.sv
// ============================================================================
// vsst_cordic
// Rotation-mode CORDIC, one iteration per register stage.
// ============================================================================
module vsst_cordic (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [31:0]     z_in,
    input  vsst_pkg::cordic_side_t side_in,
    output logic                   out_valid,
    output logic signed [31:0]     x_out,
    output logic signed [31:0]     y_out,
    output vsst_pkg::cordic_side_t side_out
);
    import vsst_pkg::*;

    logic signed [31:0] x_reg [TRIG_STEPS];
    logic signed [31:0] y_reg [TRIG_STEPS];
    logic signed [31:0] z_reg [TRIG_STEPS];
    cordic_side_t       side_reg [TRIG_STEPS];
    logic               valid_reg [TRIG_STEPS];

    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_stage
        logic signed [31:0] xc, yc, zc, dx, dy;
        logic signed [31:0] x_next, y_next, z_next;
        cordic_side_t       sc;
        logic               vc;

        if (i == 0) begin : g_first
            assign xc = CORDIC_K;
            assign yc = '0;
            assign zc = z_in;
            assign sc = side_in;
            assign vc = in_valid;
        end else begin : g_rest
            assign xc = x_reg[i-1];
            assign yc = y_reg[i-1];
            assign zc = z_reg[i-1];
            assign sc = side_reg[i-1];
            assign vc = valid_reg[i-1];
        end

        // Arithmetic shifts round toward minus infinity.
        assign dx = yc >>> i;
        assign dy = xc >>> i;

        always_comb begin
            if (zc >= 0) begin
                x_next = xc - dx;
                y_next = yc + dy;
                z_next = zc - $signed(ATAN_TAB[i]);
            end else begin
                x_next = xc + dx;
                y_next = yc - dy;
                z_next = zc + $signed(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= vc;
            end
            if (en) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= sc;
            end
        end
    end

    assign out_valid = valid_reg[TRIG_STEPS-1];
    assign x_out     = x_reg[TRIG_STEPS-1];
    assign y_out     = y_reg[TRIG_STEPS-1];
    assign side_out  = side_reg[TRIG_STEPS-1];

endmodule

### hw/rtl/vsst_div.sv
// ============================================================================
// vsst_div
// Pipelined restoring divider: (num << 32) / den, one quotient bit a stage.
// ============================================================================
module vsst_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         num_in,
    input  logic [31:0]         den_in,
    input  vsst_pkg::div_side_t side_in,
    output logic                out_valid,
    output logic [63:0]         quot_out,
    output vsst_pkg::div_side_t side_out
);
    import vsst_pkg::*;

    logic [31:0] rem_reg  [DIV_STAGES];
    logic [31:0] num_reg  [DIV_STAGES];
    logic [31:0] den_reg  [DIV_STAGES];
    logic [63:0] quot_reg [DIV_STAGES];
    div_side_t   side_reg [DIV_STAGES];
    logic        valid_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0] rc, nc, dc, rem_next;
        logic [63:0] qc;
        div_side_t   sc;
        logic        vc, ge;
        logic [32:0] trial;

        if (k == 0) begin : g_first
            assign rc = '0;
            assign nc = num_in;
            assign dc = den_in;
            assign qc = '0;
            assign sc = side_in;
            assign vc = in_valid;
        end else begin : g_rest
            assign rc = rem_reg[k-1];
            assign nc = num_reg[k-1];
            assign dc = den_reg[k-1];
            assign qc = quot_reg[k-1];
            assign sc = side_reg[k-1];
            assign vc = valid_reg[k-1];
        end

        // The dividend bits run out after 32 shifts; zeros follow.
        assign trial    = {rc, nc[31]};
        assign ge       = trial >= {1'b0, dc};
        assign rem_next = ge ? 32'(trial - {1'b0, dc}) : trial[31:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= vc;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= {nc[30:0], 1'b0};
                den_reg[k]  <= dc;
                quot_reg[k] <= {qc[62:0], ge};
                side_reg[k] <= sc;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot_out  = quot_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

### hw/rtl/vsst_mulq.sv
// ============================================================================
// vsst_mulq
// Three-stage floor(a*b / 2^32) with infinity and overflow tracking.
// ============================================================================
module vsst_mulq (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic        ainf,
    input  logic [63:0] b,
    input  logic        binf,
    output logic [63:0] prod,
    output logic        pinf
);
    logic [63:0] ll_reg, hl_reg, lh_reg, hh_reg;
    logic        zero1_reg, inf1_reg;
    logic [33:0] t_reg;
    logic [64:0] hs_reg;
    logic        zero2_reg, inf2_reg;
    logic [63:0] prod_reg;
    logic        pinf_reg;

    logic        zero_next;
    logic [33:0] t_next;
    logic [64:0] hs_next;
    logic [65:0] rhi;

    // A finite zero wins over an infinite operand.
    assign zero_next = (!ainf && a == '0) || (!binf && b == '0);
    assign t_next  = 34'(ll_reg[63:32]) + 34'(hl_reg[31:0]) + 34'(lh_reg[31:0]);
    assign hs_next = 65'(hh_reg) + 65'(hl_reg[63:32]) + 65'(lh_reg[63:32]);
    assign rhi     = 66'(hs_reg) + 66'(t_reg[33:32]);

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg    <= 64'(a[31:0])  * 64'(b[31:0]);
            hl_reg    <= 64'(a[63:32]) * 64'(b[31:0]);
            lh_reg    <= 64'(a[31:0])  * 64'(b[63:32]);
            hh_reg    <= 64'(a[63:32]) * 64'(b[63:32]);
            zero1_reg <= zero_next;
            inf1_reg  <= ainf || binf;

            t_reg     <= t_next;
            hs_reg    <= hs_next;
            zero2_reg <= zero1_reg;
            inf2_reg  <= inf1_reg;

            prod_reg  <= zero2_reg ? 64'd0 : {rhi[31:0], t_reg[31:0]};
            pinf_reg  <= !zero2_reg && (inf2_reg || rhi[65:32] != '0);
        end
    end

    assign prod = prod_reg;
    assign pinf = pinf_reg;

endmodule

### hw/rtl/vsst_scale.sv
// ============================================================================
// vsst_scale
// Scales both trig terms by Ks and twice by c, then saturates to Q16.16.
// ============================================================================
module vsst_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [30:0]         spring_gain,
    input  logic [63:0]         c_in,
    input  vsst_pkg::div_side_t side_in,
    output logic                out_valid,
    output logic [31:0]         torque,
    output logic [31:0]         stiffness,
    output logic                overflow,
    output logic                perr
);
    import vsst_pkg::*;

    logic [63:0] mt_reg, ms_reg;
    scl_side_t   side0_reg;
    logic        valid0_reg;
    scl_side_t   dly_reg   [SCL_DELAY];
    logic        vdly_reg  [SCL_DELAY];
    logic [31:0] torque_reg, stiff_reg;
    logic        ovf_reg, perr_reg, valid_out_reg;

    logic [61:0] pt, ps;
    logic [63:0] t1, s1, t2, s2;
    logic        t1inf, s1inf, t2inf, s2inf;
    logic [31:0] t_val, s_val;
    logic        t_sat, s_sat;

    assign pt = 62'(spring_gain) * 62'(side_in.smag);
    assign ps = 62'(spring_gain) * 62'(side_in.cmag);

    vsst_mulq u_mul_t1 (.aclk, .en, .a(mt_reg), .ainf(1'b0), .b(side0_reg.c),
                        .binf(side0_reg.cinf), .prod(t1), .pinf(t1inf));
    vsst_mulq u_mul_s1 (.aclk, .en, .a(ms_reg), .ainf(1'b0), .b(side0_reg.c),
                        .binf(side0_reg.cinf), .prod(s1), .pinf(s1inf));
    vsst_mulq u_mul_t2 (.aclk, .en, .a(t1), .ainf(t1inf), .b(dly_reg[2].c),
                        .binf(dly_reg[2].cinf), .prod(t2), .pinf(t2inf));
    vsst_mulq u_mul_s2 (.aclk, .en, .a(s1), .ainf(s1inf), .b(dly_reg[2].c),
                        .binf(dly_reg[2].cinf), .prod(s2), .pinf(s2inf));

    function automatic logic [32:0] saturate(input logic [63:0] m, input logic inf,
                                             input logic neg);
        logic [33:0] mag, lim;
        logic        sat;
        mag = m[63:30];
        lim = neg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
        sat = inf || (mag > lim);
        if (sat) begin
            mag = lim;
        end
        return {sat, neg ? 32'(32'd0 - mag[31:0]) : mag[31:0]};
    endfunction

    assign {t_sat, t_val} = saturate(t2, t2inf, dly_reg[SCL_DELAY-1].tneg);
    assign {s_sat, s_val} = saturate(s2, s2inf, dly_reg[SCL_DELAY-1].sneg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg    <= 1'b0;
            valid_out_reg <= 1'b0;
        end else if (en) begin
            valid0_reg    <= in_valid;
            valid_out_reg <= vdly_reg[SCL_DELAY-1];
        end
        if (en) begin
            mt_reg     <= 64'(pt);
            // The stiffness term carries the factor of two.
            ms_reg     <= {1'b0, ps, 1'b0};
            side0_reg  <= '{c: c_in, cinf: side_in.cinf, tneg: side_in.tneg,
                            sneg: side_in.sneg, perr: side_in.perr};
            torque_reg <= t_val;
            stiff_reg  <= s_val;
            ovf_reg    <= t_sat | s_sat;
            perr_reg   <= dly_reg[SCL_DELAY-1].perr;
        end
    end

    for (genvar k = 0; k < SCL_DELAY; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vdly_reg[k] <= 1'b0;
            end else if (en) begin
                vdly_reg[k] <= (k == 0) ? valid0_reg : vdly_reg[(k == 0) ? 0 : k-1];
            end
            if (en) begin
                dly_reg[k] <= (k == 0) ? side0_reg : dly_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = valid_out_reg;
    assign torque    = torque_reg;
    assign stiffness = stiff_reg;
    assign overflow  = ovf_reg;
    assign perr      = perr_reg;

endmodule

### hw/rtl/variable_stiffness_spring_torque.sv
// ============================================================================
// variable_stiffness_spring_torque
// Elastic torque and stiffness of a lever spring with adjustable preset.
// ============================================================================
//  Channel   Ports                                        Direction
//  input     s_valid/s_ready, s_motor_angle,              in
//            s_preset_position, s_link_angle
//  result    m_valid/m_ready, m_link_torque,              out
//            m_link_stiffness, m_overflow_flag, m_preset_error
//  config    cfg_wr_en, cfg_index, cfg_data               in
//
// One transaction enters per cycle unless a held result stalls the pipeline
// (1 front stage, 16 CORDIC stages, 64 divider stages, 8 scaling stages).
// The divider, one quotient bit per stage, is the deepest part.
// aresetn is synchronous; it clears the valid bits and loads the config defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ============================================================================
module variable_stiffness_spring_torque (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vsst_pkg::ANGLE_W-1:0]  s_motor_angle,
    input  logic [vsst_pkg::LEN_W-1:0]           s_preset_position,
    input  logic signed [vsst_pkg::ANGLE_W-1:0]  s_link_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vsst_pkg::OUT_W-1:0]    m_link_torque,
    output logic signed [vsst_pkg::OUT_W-1:0]    m_link_stiffness,
    output logic                                 m_overflow_flag,
    output logic                                 m_preset_error,
    input  logic                                 cfg_wr_en,
    input  logic [vsst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vsst_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import vsst_pkg::*;

    logic [KS_W-1:0]   spring_gain_reg;
    logic [LEN_W-1:0]  lever_length_reg;
    logic [LEN_W-1:0]  pulley_radius_reg;
    logic [DLIM_W-1:0] deflection_limit_reg;

    logic              en;
    logic signed [16:0] d_raw, lim, d_clamp;
    logic signed [33:0] z_full, z_red;
    logic              flip;
    logic [16:0]       lever_diff;
    cordic_side_t      front_side;

    logic              front_valid_reg;
    logic signed [31:0] front_z_reg;
    cordic_side_t      front_side_reg;

    logic              cor_valid;
    logic signed [31:0] cor_x, cor_y;
    cordic_side_t      cor_side;
    div_side_t         div_side_in;

    logic              div_valid;
    logic [63:0]       div_quot;
    div_side_t         div_side_out;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spring_gain_reg      <= KS_W'(655360);
            lever_length_reg     <= LEN_W'(52429);
            pulley_radius_reg    <= LEN_W'(15729);
            deflection_limit_reg <= DLIM_W'(1229);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_SPRING_GAIN:      spring_gain_reg      <= cfg_data[KS_W-1:0];
                REG_LEVER_LENGTH:     lever_length_reg     <= cfg_data[LEN_W-1:0];
                REG_PULLEY_RADIUS:    pulley_radius_reg    <= cfg_data[LEN_W-1:0];
                REG_DEFLECTION_LIMIT: deflection_limit_reg <= cfg_data[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is held.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Front stage: clamp the deflection, form 2d in Q2.30 and fold it
    // into [-pi/2, pi/2]; form numerator and denominator of the gain.
    assign d_raw   = 17'(s_link_angle) - 17'(s_motor_angle);
    assign lim     = $signed({4'b0, deflection_limit_reg});
    assign d_clamp = (d_raw > lim) ? lim : ((d_raw < -lim) ? -lim : d_raw);
    assign z_full  = $signed({d_clamp[14:0], 19'b0});

    always_comb begin
        flip  = 1'b0;
        z_red = z_full;
        if (z_full > HALF_PI_Q30) begin
            z_red = z_full - PI_Q30;
            flip  = 1'b1;
        end else if (z_full < -HALF_PI_Q30) begin
            z_red = z_full + PI_Q30;
            flip  = 1'b1;
        end
    end

    assign lever_diff      = 17'(lever_length_reg) - 17'(s_preset_position);
    assign front_side.num  = 32'(lever_length_reg) * 32'(s_preset_position);
    assign front_side.den  = 32'(pulley_radius_reg) * 32'(lever_diff[15:0]);
    assign front_side.perr = s_preset_position >= lever_length_reg;
    assign front_side.cinf = (s_preset_position >= lever_length_reg)
                             || (pulley_radius_reg == '0);
    assign front_side.flip = flip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (en) begin
            front_valid_reg <= s_valid;
        end
        if (en) begin
            front_z_reg    <= z_red[31:0];
            front_side_reg <= front_side;
        end
    end

    vsst_cordic u_cordic (
        .aclk, .aresetn, .en,
        .in_valid  (front_valid_reg),
        .z_in      (front_z_reg),
        .side_in   (front_side_reg),
        .out_valid (cor_valid),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .side_out  (cor_side)
    );

    // Magnitudes do not depend on the fold; only the result signs do.
    assign div_side_in.smag = cor_y[31] ? 31'(32'd0 - cor_y) : cor_y[30:0];
    assign div_side_in.cmag = cor_x[31] ? 31'(32'd0 - cor_x) : cor_x[30:0];
    assign div_side_in.tneg = cor_side.flip ? (cor_y < 0) : (cor_y > 0);
    assign div_side_in.sneg = cor_side.flip ? (cor_x > 0) : (cor_x < 0);
    assign div_side_in.perr = cor_side.perr;
    assign div_side_in.cinf = cor_side.cinf;

    vsst_div u_div (
        .aclk, .aresetn, .en,
        .in_valid  (cor_valid),
        .num_in    (cor_side.num),
        .den_in    (cor_side.den),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quot_out  (div_quot),
        .side_out  (div_side_out)
    );

    vsst_scale u_scale (
        .aclk, .aresetn, .en,
        .in_valid    (div_valid),
        .spring_gain (spring_gain_reg),
        .c_in        (div_quot),
        .side_in     (div_side_out),
        .out_valid   (m_valid),
        .torque      (m_link_torque),
        .stiffness   (m_link_stiffness),
        .overflow    (m_overflow_flag),
        .perr        (m_preset_error)
    );

    // With a preset error the torque is either zero or at a rail.
    a_perr_torque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_preset_error |->
            (m_link_torque == 32'sh7FFF_FFFF || m_link_torque == 32'sh8000_0000
             || m_link_torque == 32'sd0))
        else $error("preset error with unsaturated torque");

    // A raised overflow flag means at least one output sits at a rail.
    a_ovf_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow_flag |->
            (m_link_torque == 32'sh7FFF_FFFF || m_link_torque == 32'sh8000_0000
             || m_link_stiffness == 32'sh7FFF_FFFF
             || m_link_stiffness == 32'sh8000_0000))
        else $error("overflow flag without saturated output");

    // The pipeline only advances when the output register can move.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && !s_ready == !m_ready)
        else $error("result dropped during stall");

endmodule

### test/variable_stiffness_spring_torque_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Spring torque result checker
// Watches the input and result channels of the spring torque block and
// predicts each result from a model of its arithmetic. It compares every
// result field by field, in order, and counts the mismatches.
// ============================================================================
module variable_stiffness_spring_torque_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [vsst_pkg::ANGLE_W-1:0]  s_motor_angle,
    input  logic [vsst_pkg::LEN_W-1:0]           s_preset_position,
    input  logic signed [vsst_pkg::ANGLE_W-1:0]  s_link_angle,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [vsst_pkg::OUT_W-1:0]    m_link_torque,
    input  logic signed [vsst_pkg::OUT_W-1:0]    m_link_stiffness,
    input  logic                                 m_overflow_flag,
    input  logic                                 m_preset_error,
    input  logic                                 cfg_wr_en,
    input  logic [vsst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vsst_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending_count,
    output int                                   result_count
);
    import vsst_pkg::*;

    typedef struct packed {
        logic [31:0] torque;
        logic [31:0] stiffness;
        logic        ovf;
        logic        perr;
    } spring_result_t;

    localparam longint PI_L      = 64'd3373259426;
    localparam longint HALF_PI_L = 64'd1686629713;
    localparam longint K_L       = 64'd652032874;

    spring_result_t expected_results[$];
    logic [30:0] ks_reg;
    logic [15:0] lever_reg, radius_reg;
    logic [12:0] dlim_reg;

    // floor(a*b / 2^32); zero beats infinity, any bit above 64 is infinity.
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input bit ainf,
                                            input logic [63:0] b, input bit binf,
                                            output bit oinf);
        logic [127:0] p;
        if ((!ainf && a == 0) || (!binf && b == 0)) begin
            oinf = 0;
            return 0;
        end
        if (ainf || binf) begin
            oinf = 1;
            return 0;
        end
        p = a * b;
        oinf = (p[127:96] != 0);
        return oinf ? 64'd0 : p[95:32];
    endfunction

    function automatic logic [31:0] scale_output(input logic [63:0] trig_mag,
                                                 input bit dbl, input bit neg,
                                                 input logic [63:0] c, input bit cinf,
                                                 inout bit sat);
        logic [63:0] m, lim, mag;
        bit inf;
        m = 64'(ks_reg) * trig_mag * (dbl ? 64'd2 : 64'd1);
        lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
        m = mul_q32(m, 1'b0, c, cinf, inf);
        m = mul_q32(m, inf, c, cinf, inf);
        mag = m >> 30;
        if (inf || mag > lim) begin
            mag = lim;
            sat = 1;
        end
        if (neg) mag = -mag;
        return mag[31:0];
    endfunction

    function automatic spring_result_t predict_torque(input logic signed [15:0] q1,
                                                      input logic [15:0] q2,
                                                      input logic signed [15:0] ql);
        longint d, lim, x, y, z, dx, dy;
        bit flip, cinf, sat;
        logic [63:0] c, num, den;
        spring_result_t r;
        flip = 0; cinf = 0; sat = 0; c = 0;
        lim = longint'(dlim_reg);
        d = longint'(ql) - longint'(q1);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        z = d * 524288;
        x = K_L;
        y = 0;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1;
        end
        for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        r.perr = 0;
        if (q2 >= lever_reg) begin
            r.perr = 1;
            cinf = 1;
        end else begin
            num = 64'(lever_reg) * 64'(q2);
            den = 64'(radius_reg) * 64'(lever_reg - q2);
            if (den == 0) cinf = 1;
            else c = (num << 32) / den;
        end
        r.torque = scale_output(y < 0 ? -y : y, 1'b0, y > 0, c, cinf, sat);
        r.stiffness = scale_output(x < 0 ? -x : x, 1'b1, x < 0, c, cinf, sat);
        r.ovf = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        spring_result_t e;
        if (!aresetn) begin
            ks_reg <= 31'd655360;
            lever_reg <= 16'd52429;
            radius_reg <= 16'd15729;
            dlim_reg <= 13'd1229;
            expected_results.delete();
            fail_count = 0;
            result_count <= 0;
            pending_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_link_torque, 32'd0);
                end else begin
                    e = expected_results.pop_front();
                    if (m_link_torque !== e.torque)
                        report_mismatch("link_torque", m_link_torque, e.torque);
                    if (m_link_stiffness !== e.stiffness)
                        report_mismatch("link_stiffness", m_link_stiffness, e.stiffness);
                    if (m_overflow_flag !== e.ovf)
                        report_mismatch("overflow_flag", 32'(m_overflow_flag), 32'(e.ovf));
                    if (m_preset_error !== e.perr)
                        report_mismatch("preset_error", 32'(m_preset_error), 32'(e.perr));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_torque(s_motor_angle,
                                                          s_preset_position, s_link_angle));
            pending_count <= expected_results.size();
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    REG_SPRING_GAIN:      ks_reg <= cfg_data[30:0];
                    REG_LEVER_LENGTH:     lever_reg <= cfg_data[15:0];
                    REG_PULLEY_RADIUS:    radius_reg <= cfg_data[15:0];
                    REG_DEFLECTION_LIMIT: dlim_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

### test/variable_stiffness_spring_torque_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Spring torque block testbench
// Drives directed and random joint samples through several register settings
// with random idling and back pressure; a checker compares every result.
// ============================================================================
module variable_stiffness_spring_torque_test;
    import vsst_pkg::*;

    localparam int LATENCY = 89;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    logic signed [15:0] s_motor_angle = 0, s_link_angle = 0;
    logic [15:0] s_preset_position = 0;
    logic m_valid, m_ready = 0;
    logic signed [31:0] m_link_torque, m_link_stiffness;
    logic m_overflow_flag, m_preset_error;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [CFG_DATA_W-1:0] cfg_data = 0;
    int fail_count, pending_count, result_count;
    int idle_cycles = 0;
    bit steady_phase = 0;
    bit hold_off_req = 0;
    int sample_count = 0;

    always #4 aclk = ~aclk;

    variable_stiffness_spring_torque dut (.*);

    variable_stiffness_spring_torque_checker checker_i (.*);

    // Receiver: random stalls, or a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_off_req) begin
            m_ready <= 0;
        end else begin
            m_ready <= steady_phase || ($urandom_range(99) >= 17);
        end
    end

    initial begin
        int hold;
        wait (aresetn);
        forever begin
            wait (hold_off_req);
            hold = 0;
            while (hold < 300) begin
                @(posedge aclk);
                hold++;
            end
            hold_off_req = 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** variable_stiffness_spring_torque: FAILED **");
            $finish;
        end
    end

    // One write; the write enable then drops before the task returns, so back-to-back writes stay apart.
    task automatic write_reg(input cfg_index_t idx, input logic [30:0] value);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Offers one sample, with optional idle cycles before it.
    task automatic send_sample(input logic [15:0] q1, input logic [15:0] q2,
                               input logic [15:0] ql);
        while (!steady_phase && $urandom_range(99) < 17) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_motor_angle <= q1;
        s_preset_position <= q2;
        s_link_angle <= ql;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sample_count++;
    endtask

    task automatic finish_burst();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    // Presets are mostly below the lever length so the gain stays finite.
    task automatic random_samples(input int n, input logic [15:0] lever);
        logic [15:0] q2;
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: q2 = 16'($urandom);
                1: q2 = lever;
                default: q2 = (lever > 1) ? 16'($urandom_range(lever - 1)) : 16'd0;
            endcase
            if ($urandom_range(3) == 0)
                send_sample(16'($urandom), q2, 16'($urandom));
            else
                send_sample(16'($urandom_range(8191) - 4096), q2,
                            16'($urandom_range(8191) - 4096));
        end
        finish_burst();
    endtask

    initial begin
        logic [15:0] lever;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, zero deflection, beyond the limit, preset errors.
        send_sample(16'sh8000, 16'd0, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'd0, 16'sh8000);
        send_sample(16'd0, 16'd10000, 16'd0);
        send_sample(16'd0, 16'd10000, 16'd600);
        send_sample(16'd600, 16'd10000, 16'd0);
        send_sample(16'd0, 16'd52428, 16'd800);
        send_sample(16'd0, 16'd52429, 16'd800);
        send_sample(16'd0, 16'hFFFF, 16'd800);
        send_sample(16'd0, 16'hFFFF, 16'd0);
        send_sample(16'hFFFF, 16'd30000, 16'd0);
        finish_burst();
        drain();

        write_reg(REG_DEFLECTION_LIMIT, 31'd6434);
        write_reg(REG_SPRING_GAIN, 31'h7FFFFFFF);
        send_sample(16'sh8000, 16'd20000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'd20000, 16'sh8000);
        send_sample(16'd0, 16'd52000, 16'd3300);
        send_sample(16'd0, 16'd20000, 16'd6434);
        finish_burst();
        drain();
        write_reg(REG_SPRING_GAIN, 31'd0);
        write_reg(REG_PULLEY_RADIUS, 31'd0);
        send_sample(16'd0, 16'd60000, 16'd100);
        send_sample(16'd0, 16'd100, 16'd100);
        finish_burst();
        drain();
        write_reg(REG_SPRING_GAIN, 31'd655360);
        write_reg(REG_LEVER_LENGTH, 31'd0);
        write_reg(REG_DEFLECTION_LIMIT, 31'd8191);
        send_sample(16'd0, 16'd0, 16'd100);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'd0, 16'd500, 16'sh8000);
        finish_burst();
        drain();

        // Random phases over several register settings.
        for (int phase = 0; phase < 7; phase++) begin
            lever = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'd1
                                            : 16'($urandom_range(1, 65535));
            write_reg(REG_SPRING_GAIN, (phase == 0) ? 31'h7FFFFFFF : (phase == 1) ? 31'd0
                                       : 31'($urandom_range(1 << 22)));
            write_reg(REG_LEVER_LENGTH, 31'(lever));
            write_reg(REG_PULLEY_RADIUS, (phase == 0) ? 31'd1 : (phase == 1) ? 31'hFFFF
                                         : 31'($urandom_range(1, 65535)));
            write_reg(REG_DEFLECTION_LIMIT, (phase == 2) ? 31'd0
                                            : 31'($urandom_range(8191)));
            write_reg(cfg_index_t'($urandom_range(3)), 31'($urandom));
            steady_phase = (phase == 3);
            if (phase == 4) hold_off_req = 1;
            random_samples(240, lever);
            steady_phase = 0;
            // Sender waits for every result before the next setting.
            drain();
        end

        $display("covered %0d samples and %0d results over directed cases and seven",
                 sample_count, result_count);
        $display("random register settings, with stalls and a long result hold-off");
        if (fail_count == 0) begin
            $display("** variable_stiffness_spring_torque: PASSED **");
        end else begin
            $display("** variable_stiffness_spring_torque: FAILED **");
        end
        $finish;
    end
endmodule
